// File: hdl/particle_euler_ground_contact_top_defines.svh
// Assertion macros used by the top-level module
`ifndef PARTICLE_EULER_GROUND_CONTACT_TOP_DEFINES_SVH
`define PARTICLE_EULER_GROUND_CONTACT_TOP_DEFINES_SVH
// property that an implication holds every clock, reset masked
`define PEG_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// property that an implication holds on the clock after the antecedent
`define PEG_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/peg_pkg.sv
`timescale 1ns / 1ps
package peg_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_GROUND_Y  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BOUNCE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FRICTION  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DT_MASS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TIME_STEP = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FIXED     = 3'd5;

  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_PLACE = 1'b1;

  // datapath operations chosen by the controller
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_PLACE    = 4'd1,
    OP_MUL_DV   = 4'd2,  // product f*dt_over_mass for one axis
    OP_ADD_V    = 4'd3,  // v += round(product)
    OP_MUL_DR   = 4'd4,
    OP_ADD_R    = 4'd5,
    OP_MUL_M    = 4'd6,  // friction amount and bounce product
    OP_MUL_SQ   = 4'd7,  // squares of vx, vz, m
    OP_BOUNCE   = 4'd8,  // no operation; the bounce product is formed by OP_MUL_M
    OP_BOUNCE_W = 4'd9,  // write back vy, clamp y, decide
    OP_SQRT     = 4'd10, // one root step
    OP_MUL_SH   = 4'd11, // |c|*m for one axis
    OP_DIV      = 4'd12, // one quotient bit
    OP_SH_W     = 4'd13  // write shrunk axis
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       init;   // start of an iterative unit; driven low by peg_ctrl, unused by peg_datapath
  } cmd_t;

  typedef struct packed {
    logic below;   // position y below ground
    logic clear;   // friction clears horizontal velocity
    logic fixed;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Q32.32 to Q16.16, nearest, ties up (floor of p + half)
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
    logic signed [65:0] q;
    q = p + 66'sd32768;
    return q >>> 16;
  endfunction
endpackage

// File: hdl/peg_if.sv
`timescale 1ns / 1ps
interface peg_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] force_x, force_y, force_z, place_x, place_y, place_z;
  modport source(output valid, kind, force_x, force_y, force_z, place_x, place_y, place_z,
                 input ready);
  modport sink(input valid, kind, force_x, force_y, force_z, place_x, place_y, place_z,
               output ready);
endinterface

interface peg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  logic        ground_contact;
  modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, ground_contact,
                 input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, ground_contact,
               output ready);
endinterface

interface peg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/particle_euler_ground_contact_top.sv
`timescale 1ns / 1ps
// Place item: position loaded, velocity cleared. Step item: velocity, then position,
// per axis (skipped if fixed), then a ground check; on contact, bounce, clamp of y and
// friction, clearing or shrinking vx and vz (32-step root, then a division per axis).
// One item in flight at a time; a new item waits until the result item is taken.
// Reset (rst_n, synchronous, low): registers to defaults, state cleared, no result.
module particle_euler_ground_contact_top
  import peg_pkg::*;
(
  input logic clk,
  input logic rst_n,
  peg_in_if.sink    in_ch,
  peg_out_if.source out_ch,
  peg_cfg_if.sink   cfg_ch
);
  `include "particle_euler_ground_contact_top_defines.svh"

  cmd_t cmd;
  sts_t sts;
  logic busy, done, start;
  logic kind_r;
  logic ovalid_r;
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic contact;
  logic [31:0] frc [3];
  logic [31:0] plc [3];

  assign in_ch.ready  = !busy && !ovalid_r;
  assign start        = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign frc = '{in_ch.force_x, in_ch.force_y, in_ch.force_z};
  assign plc = '{in_ch.place_x, in_ch.place_y, in_ch.place_z};

  always_ff @(posedge clk) begin
    if (!rst_n) kind_r <= KIND_STEP;
    else if (start) kind_r <= in_ch.kind;
  end

  peg_ctrl u_ctrl (
    .clk, .rst_n, .start, .kind(in_ch.kind), .sts, .cmd, .busy, .done
  );

  peg_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_data(cfg_ch.data),
    .ld_en(start), .ld_force(frc), .ld_place(plc),
    .pos, .vel, .contact
  );

  // result register: state is stable until the next item
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (done) ovalid_r <= 1'b1;
    else if (out_ch.ready) ovalid_r <= 1'b0;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.pos_x = pos[0];
  assign out_ch.pos_y = pos[1];
  assign out_ch.pos_z = pos[2];
  assign out_ch.vel_x = vel[0];
  assign out_ch.vel_y = vel[1];
  assign out_ch.vel_z = vel[2];
  assign out_ch.ground_contact = contact;

  `PEG_ASSERT_IMP(a_no_accept_busy, clk, rst_n, busy, !in_ch.ready)
  `PEG_ASSERT_NXT(a_done_gives_valid, clk, rst_n, done, out_ch.valid)
  `PEG_ASSERT_IMP(a_place_no_contact, clk, rst_n,
    out_ch.valid && kind_r == KIND_PLACE, !out_ch.ground_contact)
endmodule

// File: hdl/peg_datapath.sv
`timescale 1ns / 1ps
module peg_datapath
  import peg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  input  logic               ld_en,
  input  logic [31:0]        ld_force [3],
  input  logic [31:0]        ld_place [3],
  output logic signed [31:0] pos [3],
  output logic signed [31:0] vel [3],
  output logic               contact
);
  // configuration
  logic signed [31:0] ground_y_r;
  logic [17:0] bounce_r;
  logic [30:0] fric_r, dtm_r;
  logic [16:0] ts_r;
  logic        fixed_r;

  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] frc_r [3];
  logic signed [31:0] plc_r [3];
  logic        contact_r;
  logic signed [65:0] prod_r;   // shared multiplier output
  logic [63:0] m_r;             // friction amount
  logic [63:0] sq_x_r, sq_z_r, mm_r;
  logic        m_big_r;
  // root unit
  logic [63:0] rx_r, rres_r, rbit_r;
  // divider: numerator |c|*m (< 2^64), divisor len
  logic [95:0] num_r;
  logic [63:0] rem_r;
  logic [95:0] quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_y_r <= '0;
      bounce_r   <= 18'd98304;
      fric_r     <= '0;
      dtm_r      <= 31'd655;
      ts_r       <= 17'd655;
      fixed_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GROUND_Y:  ground_y_r <= cfg_data;
        REG_BOUNCE:    bounce_r   <= cfg_data[17:0];
        REG_FRICTION:  fric_r     <= cfg_data[30:0];
        REG_DT_MASS:   dtm_r      <= cfg_data[30:0];
        REG_TIME_STEP: ts_r       <= cfg_data[16:0];
        REG_FIXED:     fixed_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [31:0] mag_a;
  logic [63:0] s_sum, rtry;
  logic [64:0] rem_sh;
  logic signed [31:0] ax_c;
  always_comb begin
    ax_c   = vel_r[cmd.axis];
    mag_a  = ax_c[31] ? 32'(-ax_c) : ax_c;
    s_sum  = sq_x_r + sq_z_r;
    rtry   = rres_r + rbit_r;
    rem_sh = {rem_r, num_r[95]};
  end

  // particle state and the operation chosen by cmd.op, one operation per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contact_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      if (ld_en) begin
        for (int i = 0; i < 3; i++) begin
          frc_r[i] <= ld_force[i];
          plc_r[i] <= ld_place[i];
        end
        contact_r <= 1'b0;
      end
      case (cmd.op)
        OP_PLACE: begin
          for (int i = 0; i < 3; i++) begin
            pos_r[i] <= plc_r[i];
            vel_r[i] <= '0;
          end
        end
        OP_MUL_DV: prod_r <= 66'(frc_r[cmd.axis] * $signed({1'b0, dtm_r}));
        OP_ADD_V:  vel_r[cmd.axis] <= sat32(66'(vel_r[cmd.axis]) + rnd16(prod_r));
        OP_MUL_DR: prod_r <= 66'(vel_r[cmd.axis] * $signed({1'b0, ts_r}));
        OP_ADD_R:  pos_r[cmd.axis] <= sat32(66'(pos_r[cmd.axis]) + rnd16(prod_r));
        OP_MUL_M: begin
          // axis 1: rounded friction amount, and the bounce product
          m_r <= 64'(({32'd0, mag_a} * {33'd0, fric_r} + 64'd32768) >> 16);
          prod_r <= 66'(vel_r[1] * $signed({1'b0, bounce_r}));
        end
        OP_MUL_SQ: begin
          case (cmd.axis)
            2'd0: sq_x_r <= {32'd0, mag_a} * {32'd0, mag_a};
            2'd2: sq_z_r <= {32'd0, mag_a} * {32'd0, mag_a};
            default: begin
              m_big_r <= |m_r[63:32];
              mm_r    <= {32'd0, m_r[31:0]} * {32'd0, m_r[31:0]};
            end
          endcase
        end
        OP_BOUNCE: ;
        OP_BOUNCE_W: begin
          contact_r <= 1'b1;
          vel_r[1]  <= sat32(66'(vel_r[1]) - rnd16(prod_r));
          pos_r[1]  <= ground_y_r;
          rx_r      <= s_sum;
          rres_r    <= '0;
          rbit_r    <= 64'h4000000000000000;
          if (m_big_r || mm_r >= s_sum) begin
            vel_r[0] <= '0;
            vel_r[2] <= '0;
          end
        end
        OP_SQRT: begin
          if (rbit_r != 0) begin
            if (rx_r >= rtry) begin
              rx_r   <= rx_r - rtry;
              rres_r <= (rres_r >> 1) + rbit_r;
            end else begin
              rres_r <= rres_r >> 1;
            end
            rbit_r <= rbit_r >> 2;
          end
        end
        OP_MUL_SH: begin
          num_r  <= 96'({32'd0, mag_a} * {32'd0, m_r[31:0]});
          rem_r  <= '0;
          quo_r  <= '0;
        end
        OP_DIV: begin
          // restoring division, one bit each cycle
          if (rem_sh >= {1'b0, rres_r}) begin
            rem_r <= 64'(rem_sh - {1'b0, rres_r});
            quo_r <= {quo_r[94:0], 1'b1};
          end else begin
            rem_r <= rem_sh[63:0];
            quo_r <= {quo_r[94:0], 1'b0};
          end
          num_r  <= {num_r[94:0], 1'b0};
        end
        OP_SH_W: begin
          if (ax_c[31])
            vel_r[cmd.axis] <= sat32(66'(ax_c) + 66'(quo_r));
          else
            vel_r[cmd.axis] <= sat32(66'(ax_c) - 66'(quo_r));
        end
        default: ;
      endcase
    end
  end

  assign sts.below = pos_r[1] < ground_y_r;
  assign sts.clear = m_big_r || (mm_r >= s_sum);
  assign sts.fixed = fixed_r;
  assign pos     = pos_r;
  assign vel     = vel_r;
  assign contact = contact_r;
endmodule

// File: hdl/peg_ctrl.sv
`timescale 1ns / 1ps
module peg_ctrl
  import peg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic kind,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);
  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_PLACE  = 12'b000000000010,
    S_MDV    = 12'b000000000100,
    S_AV     = 12'b000000001000,
    S_MDR    = 12'b000000010000,
    S_AR     = 12'b000000100000,
    S_CHECK  = 12'b000001000000,
    S_MM     = 12'b000010000000,
    S_SQ     = 12'b000100000000,
    S_BW     = 12'b001000000000,
    S_ROOT   = 12'b010000000000,
    S_SHR    = 12'b100000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [1:0] sub_r, sub_nxt;   // shrink phase: mul, div, write

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
      cnt_r   <= '0;
      sub_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
      sub_r   <= sub_nxt;
    end
  end

  // sequencing of one item
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    sub_nxt   = sub_r;
    cmd       = '{op: OP_NONE, axis: axis_r, init: 1'b0};
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        axis_nxt = '0;
        if (start) state_nxt = (kind == KIND_PLACE) ? S_PLACE : S_MDV;
      end
      S_PLACE: begin
        cmd.op = OP_PLACE;
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      S_MDV: begin
        if (sts.fixed) state_nxt = S_CHECK;
        else begin
          cmd.op = OP_MUL_DV;
          state_nxt = S_AV;
        end
      end
      S_AV: begin
        cmd.op = OP_ADD_V;
        if (axis_r == 2'd2) begin
          axis_nxt = '0;
          state_nxt = S_MDR;
        end else begin
          axis_nxt = axis_r + 2'd1;
          state_nxt = S_MDV;
        end
      end
      S_MDR: begin
        cmd.op = OP_MUL_DR;
        state_nxt = S_AR;
      end
      S_AR: begin
        cmd.op = OP_ADD_R;
        if (axis_r == 2'd2) begin
          axis_nxt = '0;
          state_nxt = S_CHECK;
        end else begin
          axis_nxt = axis_r + 2'd1;
          state_nxt = S_MDR;
        end
      end
      S_CHECK: begin
        if (sts.below) begin
          state_nxt = S_MM;
        end else begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MM: begin
        cmd.op = OP_MUL_M;
        cmd.axis = 2'd1;
        axis_nxt = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_MUL_SQ;
        if (axis_r == 2'd2) state_nxt = S_BW;
        else axis_nxt = axis_r + 2'd1;
      end
      S_BW: begin
        cmd.op = OP_BOUNCE_W;
        cnt_nxt = '0;
        if (sts.clear) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end else state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.op = OP_SQRT;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd31) begin
          axis_nxt = '0;
          sub_nxt = '0;
          state_nxt = S_SHR;
        end
      end
      S_SHR: begin
        case (sub_r)
          2'd0: begin
            cmd.op = OP_MUL_SH;
            cnt_nxt = '0;
            sub_nxt = 2'd1;
          end
          2'd1: begin
            cmd.op = OP_DIV;
            cnt_nxt = cnt_r + 7'd1;
            if (cnt_r == 7'd95) sub_nxt = 2'd2;
          end
          default: begin
            cmd.op = OP_SH_W;
            sub_nxt = '0;
            if (axis_r == 2'd2) begin
              done = 1'b1;
              state_nxt = S_IDLE;
            end else axis_nxt = 2'd2;
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
endmodule

// File: dv/peg_tb_if.sv
`timescale 1ns / 1ps
// Channel interfaces for the particle block are declared with the RTL (peg_if.sv).
// This file holds the item and state types used by the driver and the checker.
package peg_tb_pkg;
  typedef struct {
    logic        kind;
    logic [31:0] fx, fy, fz, px, py, pz;
  } particle_item_t;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic        contact;
  } particle_state_t;
endpackage

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import peg_pkg::*;
  import peg_tb_pkg::*;

  logic clk;
  logic rst_n;

  peg_in_if  in_ch ();
  peg_out_if out_ch ();
  peg_cfg_if cfg_ch ();

  particle_euler_ground_contact_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor copy of registers and particle state
  logic signed [31:0] m_ground;
  logic [17:0]        m_bounce;
  logic [30:0]        m_fric;
  logic [30:0]        m_dtm;
  logic [16:0]        m_tstep;
  logic               m_fixed;
  logic signed [31:0] m_pos [3];
  logic signed [31:0] m_vel [3];

  particle_item_t  pending_items [$];
  particle_state_t expected_states [$];
  int errors = 0;
  int wdog = 0;
  bit stim_done = 0;
  bit in_acc = 0;
  bit out_acc = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Q32.32 to Q16.16, nearest, ties toward plus infinity
  function automatic logic signed [127:0] half_up(input logic signed [127:0] p);
    return (p + 128'sd32768) >>> 16;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] friction_shrink(input logic signed [31:0] c,
      input logic [127:0] m, input logic [127:0] len);
    logic [127:0] mag, d;
    logic signed [127:0] sd;
    mag = (c < 0) ? -128'(c) : 128'(c);
    d = (mag * m) / len;
    sd = (c < 0) ? -$signed(d) : $signed(d);
    return clip32(128'(c) - sd);
  endfunction

  // advance the particle by one item and return the state that should come out
  function automatic particle_state_t advance_particle(input particle_item_t it);
    particle_state_t r;
    logic signed [31:0] f [3];
    logic signed [31:0] vx, vy, vz;
    logic [127:0] m, s, len, avy, avx, avz;
    r.contact = 0;
    f[0] = it.fx; f[1] = it.fy; f[2] = it.fz;
    if (it.kind == KIND_PLACE) begin
      m_pos[0] = it.px; m_pos[1] = it.py; m_pos[2] = it.pz;
      for (int i = 0; i < 3; i++) m_vel[i] = 0;
    end else begin
      if (!m_fixed) begin
        for (int i = 0; i < 3; i++)
          m_vel[i] = clip32(128'(m_vel[i]) + half_up(128'(f[i]) * $signed({1'b0, m_dtm})));
        for (int i = 0; i < 3; i++)
          m_pos[i] = clip32(128'(m_pos[i]) + half_up(128'(m_vel[i]) * $signed({1'b0, m_tstep})));
      end
      if (m_pos[1] < m_ground) begin
        vx = m_vel[0]; vy = m_vel[1]; vz = m_vel[2];
        avy = (vy < 0) ? -128'(vy) : 128'(vy);
        avx = (vx < 0) ? -128'(vx) : 128'(vx);
        avz = (vz < 0) ? -128'(vz) : 128'(vz);
        m = half_up($signed(avy * m_fric));
        s = avx * avx + avz * avz;
        r.contact = 1;
        m_vel[1] = clip32(128'(vy) - half_up(128'(vy) * $signed({1'b0, m_bounce})));
        if (m >= (128'd1 << 32) || m * m >= s) begin
          m_vel[0] = 0;
          m_vel[2] = 0;
        end else begin
          len = root64(s[63:0]);
          m_vel[0] = friction_shrink(vx, m, len);
          m_vel[2] = friction_shrink(vz, m, len);
        end
        m_pos[1] = m_ground;
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.pos[i] = m_pos[i];
      r.vel[i] = m_vel[i];
    end
    return r;
  endfunction

  // handshakes seen at the rising edge
  always @(posedge clk) begin
    in_acc  <= rst_n && in_ch.valid && in_ch.ready;
    out_acc <= rst_n && out_ch.valid && out_ch.ready;
  end

  // input driver: random gap before each item
  int in_gap = 0;
  initial begin
    in_ch.valid = 0; in_ch.kind = 0;
    in_ch.force_x = 0; in_ch.force_y = 0; in_ch.force_z = 0;
    in_ch.place_x = 0; in_ch.place_y = 0; in_ch.place_z = 0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        expected_states.push_back(advance_particle(pending_items.pop_front()));
        in_gap <= $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
        in_ch.valid <= 0;
      end else if (!in_ch.valid && pending_items.size() > 0) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else begin
          in_ch.valid   <= 1;
          in_ch.kind    <= pending_items[0].kind;
          in_ch.force_x <= pending_items[0].fx;
          in_ch.force_y <= pending_items[0].fy;
          in_ch.force_z <= pending_items[0].fz;
          in_ch.place_x <= pending_items[0].px;
          in_ch.place_y <= pending_items[0].py;
          in_ch.place_z <= pending_items[0].pz;
        end
      end
    end
  end

  // result ready with random stalls
  int out_gap = 0;
  initial out_ch.ready = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) begin
        out_gap <= $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
        out_ch.ready <= 0;
      end else if (!out_ch.ready) begin
        if (out_gap > 0) out_gap <= out_gap - 1;
        else out_ch.ready <= 1;
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    particle_state_t e;
    logic [31:0] got [6];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got[0] = out_ch.pos_x; got[1] = out_ch.pos_y; got[2] = out_ch.pos_z;
      got[3] = out_ch.vel_x; got[4] = out_ch.vel_y; got[5] = out_ch.vel_z;
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected result item, pos_x %h", $time, got[0]);
        errors++;
      end else begin
        e = expected_states.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (got[i] !== (i < 3 ? e.pos[i] : e.vel[i - 3])) begin
            $display("%0t: field %0d expected %h actual %h", $time, i,
                     (i < 3 ? e.pos[i] : e.vel[i - 3]), got[i]);
            errors++;
          end
        end
        if (out_ch.ground_contact !== e.contact) begin
          $display("%0t: ground_contact expected %b actual %b", $time, e.contact,
                   out_ch.ground_contact);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no accepted item on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || stim_done)
      wdog <= 0;
    else if (rst_n && wdog >= 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      wdog <= wdog + 1;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 0;
    case (idx)
      REG_GROUND_Y:  m_ground = val;
      REG_BOUNCE:    m_bounce = val[17:0];
      REG_FRICTION:  m_fric   = val[30:0];
      REG_DT_MASS:   m_dtm    = val[30:0];
      REG_TIME_STEP: m_tstep  = val[16:0];
      REG_FIXED:     m_fixed  = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid || expected_states.size() > 0)
      @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
    endcase
  endfunction

  task automatic add_item(input logic k, input logic [31:0] fx, fy, fz, px, py, pz);
    particle_item_t it;
    it.kind = k; it.fx = fx; it.fy = fy; it.fz = fz;
    it.px = px; it.py = py; it.pz = pz;
    pending_items.push_back(it);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) begin
      // mostly steps from a recent placement near ground
      if ($urandom_range(0, 7) == 0)
        add_item(KIND_PLACE, $urandom, $urandom, $urandom, rand_val(),
                 $signed($urandom_range(0, 32'h40000)) - 32'sh10000 + m_ground, rand_val());
      else
        add_item(KIND_STEP, rand_val(), rand_val(), rand_val(), $urandom, $urandom, $urandom);
    end
  endtask

  // stimulus and register phases
  initial begin
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    m_ground = 0; m_bounce = 98304; m_fric = 0; m_dtm = 655; m_tstep = 655; m_fixed = 0;
    for (int i = 0; i < 3; i++) begin
      m_pos[i] = 0; m_vel[i] = 0;
    end
    rst_n = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: defaults, extremes, exact ground, contact
    add_item(KIND_STEP, 32'h7fffffff, 32'h80000000, 0, 1, 2, 3);
    add_item(KIND_PLACE, 5, 6, 7, 32'h7fffffff, 32'h00000000, 32'h80000000);
    add_item(KIND_STEP, 0, 0, 0, 0, 0, 0);
    add_item(KIND_PLACE, 0, 0, 0, 32'h10000, 32'hffff0000, 32'h10000);
    add_item(KIND_STEP, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0, 0);
    add_item(KIND_PLACE, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff);
    add_item(KIND_STEP, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 0);
    wait_drained();

    write_reg(REG_FRICTION, 32'h00008000);
    write_reg(REG_DT_MASS, 32'h00010000);
    write_reg(REG_TIME_STEP, 32'h00010000);
    write_reg(REG_GROUND_Y, 32'h00010000);
    write_reg(REG_BOUNCE, 32'h00020000);
    add_item(KIND_PLACE, 0, 0, 0, 0, 32'h00010000, 0);
    add_item(KIND_STEP, 32'h00040000, 32'hfff00000, 32'h00030000, 0, 0, 0);
    add_item(KIND_PLACE, 0, 0, 0, 0, 32'h00020000, 0);
    add_item(KIND_STEP, 32'h00100000, 32'hfffe0000, 32'h00000000, 0, 0, 0);
    add_item(KIND_STEP, 0, 32'hfffe0000, 0, 0, 0, 0);
    add_random(60);
    wait_drained();

    write_reg(REG_FIXED, 1);
    write_reg(REG_GROUND_Y, 32'h7fffffff);
    write_reg(3'd7, 32'hffffffff);
    add_item(KIND_PLACE, 0, 0, 0, 5, 32'h7ffffffe, 5);
    add_item(KIND_STEP, 1, 2, 3, 0, 0, 0);
    add_random(40);
    wait_drained();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_FIXED, (ph == 3));
      write_reg(REG_GROUND_Y, (ph == 4) ? 32'h80000000 : rand_val());
      write_reg(REG_BOUNCE, (ph == 1) ? 0 : (ph == 2) ? 32'hffffffff : $urandom_range(0, 131072));
      write_reg(REG_FRICTION, (ph == 2) ? 32'hffffffff : (ph == 1) ? 0 :
                $urandom_range(0, 32'h30000));
      write_reg(REG_DT_MASS, (ph == 5) ? 32'hffffffff : (ph == 1) ? 0 :
                $urandom_range(0, 32'h20000));
      write_reg(REG_TIME_STEP, (ph == 5) ? 32'hffffffff : (ph == 1) ? 0 :
                $urandom_range(0, 65536));
      add_random(100);
      wait_drained();
    end

    stim_done = 1;
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
